// ----- rtl/core/hcbp_pkg.sv -----
// hcbp_pkg: shared types and constants of the huffman code bit packer
// no dependencies; used by the channel interfaces, the code table and the top level

package hcbp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned SymW     = 8;
  localparam int unsigned LenW     = 6;
  localparam int unsigned CodeW    = 32;
  // pending bits (at most 7) plus one full code
  localparam int unsigned StreamW  = 40;
  // complete bytes one code can finish
  localparam int unsigned MaxBytes = 4;
  localparam int unsigned ResCntW  = 3;
  localparam int unsigned PendW    = 7;
  localparam int unsigned PendCntW = 3;

  typedef enum logic [1:0] {
    CmdLoad   = 2'd0,
    CmdEncode = 2'd1,
    CmdFlush  = 2'd2
  } cmd_e;

  // table write request
  typedef struct packed {
    logic            en;
    logic [SymW-1:0] symbol;
    logic [LenW-1:0] len;
    logic [CodeW-1:0] bits;
  } load_t;

  // registered table lookup
  typedef struct packed {
    logic             hit;
    logic [LenW-1:0]  len;
    logic [CodeW-1:0] bits;
  } entry_t;

endpackage

// ----- rtl/core/hcbp_if.sv -----
// hcbp_in_if / hcbp_out_if: valid-ready channels of the huffman code bit packer
// depends on hcbp_pkg for field widths

interface hcbp_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     command;
  logic [hcbp_pkg::SymW-1:0]      symbol;
  logic [hcbp_pkg::LenW-1:0]      code_length;
  logic [hcbp_pkg::CodeW-1:0]     code_value;

  modport source (output valid, command, symbol, code_length, code_value, input ready);
  modport sink   (input valid, command, symbol, code_length, code_value, output ready);
endinterface

interface hcbp_out_if;
  logic                           valid;
  logic                           ready;
  logic [hcbp_pkg::ByteW-1:0]     out_byte;
  logic                           last;
  logic                           error;

  modport source (output valid, out_byte, last, error, input ready);
  modport sink   (input valid, out_byte, last, error, output ready);
endinterface

// ----- rtl/core/hcbp_table.sv -----
// hcbp_table: code table memory with per-entry valid marks and registered lookup
// depends on hcbp_pkg (load_t, entry_t)

module hcbp_table #(
  parameter int unsigned SYMBOLS = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hcbp_pkg::load_t           load_i,
  input  logic                      rd_en_i,
  input  logic [hcbp_pkg::SymW-1:0] rd_symbol_i,
  output hcbp_pkg::entry_t          entry_o
);

  localparam int unsigned IdxW   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int unsigned RangeW = hcbp_pkg::SymW + 1;
  localparam int unsigned EntryW = hcbp_pkg::LenW + hcbp_pkg::CodeW;

  logic [EntryW-1:0]  mem_q [SYMBOLS];
  logic [SYMBOLS-1:0] valid_q;
  logic [EntryW-1:0]  rdata_q;
  logic               hit_q;

  logic            wr_in_range;
  logic            rd_in_range;
  logic [IdxW-1:0] wr_idx;
  logic [IdxW-1:0] rd_idx;

  assign wr_in_range = {1'b0, load_i.symbol} < RangeW'(SYMBOLS);
  assign rd_in_range = {1'b0, rd_symbol_i} < RangeW'(SYMBOLS);
  assign wr_idx      = load_i.symbol[IdxW-1:0];
  assign rd_idx      = rd_symbol_i[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (load_i.en && wr_in_range) begin
      mem_q[wr_idx] <= {load_i.len, load_i.bits};
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (load_i.en && wr_in_range) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= rd_in_range && valid_q[rd_idx];
      end
    end
  end

  assign entry_o.hit  = hit_q;
  assign entry_o.len  = rdata_q[EntryW-1 -: hcbp_pkg::LenW];
  assign entry_o.bits = rdata_q[hcbp_pkg::CodeW-1:0];

endmodule

// ----- rtl/core/huffman_code_bit_packer.sv -----
// huffman_code_bit_packer: table-driven huffman encoder, codes packed msb first into bytes
// depends on hcbp_pkg, hcbp_in_if / hcbp_out_if and hcbp_table
//
//   channel | dir | fields                                       | handshake
//   in_i    | in  | command, symbol, code_length, code_value     | valid/ready
//   out_o   | out | out_byte, last, error                        | valid/ready
//
// an item is taken in every cycle while the work register drains; an accepted item goes
// into the work register and table lookup registers, and its result into the output buffer.
// an encode emits 0 to 4 bytes, one per cycle from the output buffer while out_o is ready;
// the next result-making item waits in the work register until the last buffered byte leaves.
// loads, empty flushes and codes that finish no byte never wait on the output side.
// reset clears the valid marks and pending bits at once; table data is undefined until loaded.
// a stalled output holds its byte; back pressure reaches in_i.ready combinationally.

module huffman_code_bit_packer #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned SYMBOLS      = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hcbp_in_if.sink           in_i,
  hcbp_out_if.source        out_o
);

  // longest code kept by a load
  localparam int unsigned LenLim = (MAX_CODE_LEN < hcbp_pkg::CodeW) ? MAX_CODE_LEN
                                                                     : hcbp_pkg::CodeW;

  localparam int unsigned SW = hcbp_pkg::StreamW;
  localparam int unsigned BW = hcbp_pkg::MaxBytes * hcbp_pkg::ByteW;

  // ---------------- accept stage ----------------
  logic             in_acc;
  hcbp_pkg::cmd_e   cmd_in;
  hcbp_pkg::load_t  load;
  logic             rd_en;
  logic [hcbp_pkg::LenW-1:0] len_sat;

  assign in_acc = in_i.valid && in_i.ready;
  assign cmd_in = hcbp_pkg::cmd_e'(in_i.command);

  // lengths beyond the limit saturate
  assign len_sat = (in_i.code_length > hcbp_pkg::LenW'(LenLim)) ? hcbp_pkg::LenW'(LenLim)
                                                                : in_i.code_length;

  assign load.en     = in_acc && (cmd_in == hcbp_pkg::CmdLoad);
  assign load.symbol = in_i.symbol;
  assign load.len    = len_sat;
  assign load.bits   = in_i.code_value;
  assign rd_en       = in_acc && (cmd_in == hcbp_pkg::CmdEncode);

  hcbp_pkg::entry_t entry;

  hcbp_table #(
    .SYMBOLS (SYMBOLS)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .rd_en_i     (rd_en),
    .rd_symbol_i (in_i.symbol),
    .entry_o     (entry)
  );

  // ---------------- work stage ----------------
  logic           work_v_q;
  hcbp_pkg::cmd_e work_cmd_q;
  logic           work_take;

  logic [hcbp_pkg::PendW-1:0]    pend_bits_q, pend_bits_d;
  logic [hcbp_pkg::PendCntW-1:0] pend_cnt_q, pend_cnt_d;

  logic [SW-1:0]                 pend_top;   // pending bits left-aligned, zero padded
  logic [SW-1:0]                 code_top;   // code bits left-aligned
  logic [SW-1:0]                 stream;     // pending bits followed by the code
  logic [SW-1:0]                 rem;        // stream after the complete bytes
  logic [hcbp_pkg::LenW-1:0]     total;      // bits in stream, at most 39
  logic [hcbp_pkg::ResCntW-1:0]  n_res;
  logic [BW-1:0]                 res_bytes;
  logic                          res_err;

  // output buffer
  logic [BW-1:0]                 buf_q;
  logic [hcbp_pkg::ResCntW-1:0]  buf_cnt_q;
  logic                          buf_err_q;
  logic                          buf_free;
  logic                          out_pop;

  always_comb begin
    pend_top = {pend_bits_q, (SW - hcbp_pkg::PendW)'(0)} << (3'd7 - pend_cnt_q);
    code_top = {entry.bits, (SW - hcbp_pkg::CodeW)'(0)}
               << (hcbp_pkg::LenW'(hcbp_pkg::CodeW) - entry.len);
    stream   = pend_top | (code_top >> pend_cnt_q);
    total    = {3'b000, pend_cnt_q} + entry.len;
    rem      = stream << {total[5:3], 3'b000};

    n_res       = '0;
    res_bytes   = '0;
    res_err     = 1'b0;
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;

    unique case (work_cmd_q)
      hcbp_pkg::CmdEncode: begin
        if (entry.hit) begin
          n_res       = total[5:3];
          res_bytes   = stream[SW-1 -: BW];
          pend_cnt_d  = total[2:0];
          pend_bits_d = rem[SW-1 -: hcbp_pkg::PendW] >> (3'd7 - total[2:0]);
        end else begin
          // missing entry: one error result, pending bits untouched
          n_res   = hcbp_pkg::ResCntW'(1);
          res_err = 1'b1;
        end
      end
      hcbp_pkg::CmdFlush: begin
        if (pend_cnt_q != '0) begin
          n_res       = hcbp_pkg::ResCntW'(1);
          res_bytes   = {pend_top[SW-1 -: hcbp_pkg::ByteW], (BW - hcbp_pkg::ByteW)'(0)};
          pend_bits_d = '0;
          pend_cnt_d  = '0;
        end
      end
      default: ;  // loads finished at accept, unused code ignored
    endcase
  end

  assign out_pop   = out_o.valid && out_o.ready;
  assign buf_free  = (buf_cnt_q == '0) ||
                     ((buf_cnt_q == hcbp_pkg::ResCntW'(1)) && out_o.ready);
  assign work_take = work_v_q && ((n_res == '0) || buf_free);
  assign in_i.ready = !work_v_q || work_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_v_q    <= 1'b0;
      work_cmd_q  <= hcbp_pkg::CmdLoad;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
    end else begin
      if (in_i.ready) begin
        work_v_q   <= in_i.valid;
        work_cmd_q <= cmd_in;
      end
      if (work_take) begin
        pend_bits_q <= pend_bits_d;
        pend_cnt_q  <= pend_cnt_d;
      end
    end
  end

  // ---------------- output buffer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_cnt_q <= '0;
      buf_err_q <= 1'b0;
    end else if (work_take && (n_res != '0)) begin
      buf_cnt_q <= n_res;
      buf_err_q <= res_err;
    end else if (out_pop) begin
      buf_cnt_q <= buf_cnt_q - hcbp_pkg::ResCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (work_take && (n_res != '0)) begin
      buf_q <= res_bytes;
    end else if (out_pop) begin
      buf_q <= buf_q << hcbp_pkg::ByteW;
    end
  end

  assign out_o.valid    = (buf_cnt_q != '0);
  assign out_o.out_byte = buf_q[BW-1 -: hcbp_pkg::ByteW];
  assign out_o.last     = (buf_cnt_q == hcbp_pkg::ResCntW'(1));
  assign out_o.error    = buf_err_q;

endmodule

// ----- dv/hcbp_pack_checker.sv -----
// hcbp_pack_checker: watches both channels of the huffman code bit packer, predicts
// the packed bytes of every accepted item and compares them with what comes out
// depends on hcbp_pkg and the hcbp_in_if / hcbp_out_if channel interfaces

module hcbp_pack_checker
  import hcbp_pkg::*;
#(
  parameter int unsigned MaxCodeLen = 32,
  parameter int unsigned Symbols    = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcbp_in_if          in_mon,
  hcbp_out_if         out_mon,
  output int unsigned fail_count_o,
  output int unsigned waiting_count_o,
  output int unsigned bytes_checked_o,
  output int unsigned errors_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LenLimit = (MaxCodeLen < CodeW) ? MaxCodeLen : CodeW;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last;
    logic             error;
  } packed_byte_t;

  // own copy of the code table and the partial byte
  logic [LenW-1:0]     code_len_tbl  [Symbols];
  logic [CodeW-1:0]    code_bits_tbl [Symbols];
  bit                  code_known    [Symbols];
  logic [PendW-1:0]    held_bits;
  int unsigned         held_count;

  packed_byte_t        predicted_bytes[$];
  int unsigned         mismatches  = 0;
  int unsigned         bytes_seen  = 0;
  int unsigned         errors_seen = 0;

  always @(posedge clk_i or negedge rst_ni) begin : watch
    packed_byte_t     want;
    packed_byte_t     item;
    logic [ByteW-1:0] acc;
    logic [LenW-1:0]  len;
    int unsigned      cnt;
    int unsigned      made;
    int               i;
    if (!rst_ni) begin
      for (i = 0; i < Symbols; i++) code_known[i] = 1'b0;
      held_bits  = '0;
      held_count = 0;
    end else begin
      // results first: none can stem from an item taken at this same edge
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (predicted_bytes.size() == 0) begin
          $error("unexpected result: out_byte %02h last %0b error %0b",
                 out_mon.out_byte, out_mon.last, out_mon.error);
          mismatches++;
        end else begin
          want = predicted_bytes.pop_front();
          if (out_mon.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.out_byte, out_mon.out_byte);
            mismatches++;
          end
          if (out_mon.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, out_mon.last);
            mismatches++;
          end
          if (out_mon.error !== want.error) begin
            $error("error: expected %0b, actual %0b", want.error, out_mon.error);
            mismatches++;
          end
          if (want.error) errors_seen++;
          else bytes_seen++;
        end
      end

      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        case (in_mon.command)
          CmdLoad: begin
            if (in_mon.symbol < Symbols) begin
              len = in_mon.code_length;
              if (len > LenLimit) len = LenW'(LenLimit);
              code_len_tbl[in_mon.symbol]  = len;
              code_bits_tbl[in_mon.symbol] = in_mon.code_value;
              code_known[in_mon.symbol]    = 1'b1;
            end
          end
          CmdEncode: begin
            if (in_mon.symbol >= Symbols || !code_known[in_mon.symbol]) begin
              // missing entry, partial byte stays as it is
              item.out_byte = '0;
              item.last     = 1'b1;
              item.error    = 1'b1;
              predicted_bytes.push_back(item);
            end else begin
              acc  = {1'b0, held_bits};
              cnt  = held_count;
              made = 0;
              for (i = int'(code_len_tbl[in_mon.symbol]); i > 0; i--) begin
                acc = {acc[ByteW-2:0], code_bits_tbl[in_mon.symbol][i-1]};
                cnt++;
                if (cnt == ByteW) begin
                  item.out_byte = acc;
                  item.last     = 1'b0;
                  item.error    = 1'b0;
                  predicted_bytes.push_back(item);
                  made++;
                  acc = '0;
                  cnt = 0;
                end
              end
              held_bits  = acc[PendW-1:0];
              held_count = cnt;
              if (made > 0) predicted_bytes[predicted_bytes.size()-1].last = 1'b1;
            end
          end
          CmdFlush: begin
            if (held_count != 0) begin
              acc = {1'b0, held_bits};
              acc = acc << (ByteW - held_count);
              item.out_byte = acc;
              item.last     = 1'b1;
              item.error    = 1'b0;
              predicted_bytes.push_back(item);
              held_bits  = '0;
              held_count = 0;
            end
          end
          default: ;
        endcase
      end
    end
    fail_count_o     <= mismatches;
    waiting_count_o  <= predicted_bytes.size();
    bytes_checked_o  <= bytes_seen;
    errors_checked_o <= errors_seen;
  end

endmodule

// ----- dv/huffman_code_bit_packer_test.sv -----
// huffman_code_bit_packer_test: drives table loads, encodes and flushes into the packer
// under random idling on both channels, and reports the verdict of hcbp_pack_checker
// depends on hcbp_pkg, the channel interfaces, the packer and the checker

module huffman_code_bit_packer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hcbp_pkg::*;

  localparam int unsigned MaxCodeLen  = 32;
  localparam int unsigned Symbols     = 256;
  // worst case is far below this: ~260 items, each with the longest idle gap and
  // four bytes that each wait out the longest stall
  localparam int unsigned CycleLimit  = 200000;
  // cycles to wait after the last expected byte
  localparam int unsigned DrainCycles = 20;
  // the fourth command code, which the block ignores
  localparam logic [1:0]  CmdReserved = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;

  hcbp_in_if  in_ch ();
  hcbp_out_if out_ch ();

  int unsigned fail_count;
  int unsigned waiting_count;
  int unsigned bytes_checked;
  int unsigned errors_checked;
  int unsigned items_sent;
  int unsigned cycle_count = 0;

  // idling on both sides is switched per phase
  bit          idling;
  // symbols that have a table entry, so encodes can mostly hit
  bit          is_loaded [Symbols];
  logic [SymW-1:0] loaded_syms[$];

  huffman_code_bit_packer #(
    .MAX_CODE_LEN (MaxCodeLen),
    .SYMBOLS      (Symbols)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  hcbp_pack_checker #(
    .MaxCodeLen (MaxCodeLen),
    .Symbols    (Symbols)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .fail_count_o     (fail_count),
    .waiting_count_o  (waiting_count),
    .bytes_checked_o  (bytes_checked),
    .errors_checked_o (errors_checked)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // watchdog
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles, %0d results still expected",
             cycle_count, waiting_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // output side: random stall bursts while idling is on, else always ready
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idling && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // one item on in_ch; returns in the time step of its acceptance with valid
  // still high, so a following item keeps valid up without a dip
  task automatic send_item(input logic [1:0] cmd, input logic [SymW-1:0] sym,
                           input logic [LenW-1:0] len, input logic [CodeW-1:0] val);
    if (idling && $urandom_range(0, 4) == 0) begin
      // idle burst, payload is junk while valid is low
      in_ch.valid       <= 1'b0;
      in_ch.command     <= 2'($urandom);
      in_ch.symbol      <= SymW'($urandom);
      in_ch.code_length <= LenW'($urandom);
      in_ch.code_value  <= $urandom;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.symbol      <= sym;
    in_ch.code_length <= len;
    in_ch.code_value  <= val;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    items_sent++;
    if (cmd == CmdLoad && !is_loaded[sym]) begin
      is_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  // random traffic: mostly loads and encodes of loaded symbols, some flushes,
  // some encodes of missing entries and a few reserved commands
  task automatic run_traffic(input int unsigned count);
    int unsigned     done;
    int unsigned     pick;
    int unsigned     len_pick;
    logic [SymW-1:0] sym;
    logic [LenW-1:0] len;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      sym  = SymW'($urandom);
      if (pick < 30) begin
        // lengths are mostly short, some long, some past the limit, a few empty
        len_pick = $urandom_range(0, 19);
        if (len_pick == 0) len = '0;
        else if (len_pick < 3) len = LenW'($urandom_range(33, 63));
        else if (len_pick < 7) len = LenW'($urandom_range(13, 32));
        else len = LenW'($urandom_range(1, 12));
        send_item(CmdLoad, sym, len, $urandom);
        done++;
      end else if (pick < 86) begin
        if (loaded_syms.size() > 0 && $urandom_range(0, 9) != 0)
          sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        send_item(CmdEncode, sym, LenW'($urandom), $urandom);
        done++;
      end else if (pick < 96) begin
        send_item(CmdFlush, sym, LenW'($urandom), $urandom);
        done++;
      end else begin
        // ignored by the block, not counted
        send_item(CmdReserved, sym, LenW'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    idling            = 1'b0;
    items_sent        = 0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CmdLoad;
    in_ch.symbol      = '0;
    in_ch.code_length = '0;
    in_ch.code_value  = '0;
    for (int s = 0; s < Symbols; s++) is_loaded[s] = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, with idling on
    idling = 1'b1;
    // encode before any load: missing entry gives an error result
    send_item(CmdEncode, 8'h00, '0, '0);
    // flush with nothing pending: no result
    send_item(CmdFlush, 8'h00, '0, '0);
    // reserved command with all fields at their top
    send_item(CmdReserved, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
    // zero-length code is valid and emits nothing
    send_item(CmdLoad, 8'h00, 6'd0, 32'hFFFF_FFFF);
    send_item(CmdEncode, 8'h00, '0, '0);
    // longest code, all ones: four full bytes
    send_item(CmdLoad, 8'hFF, 6'd32, 32'hFFFF_FFFF);
    send_item(CmdEncode, 8'hFF, '0, '0);
    // length past the limit saturates to 32
    send_item(CmdLoad, 8'h01, 6'h3F, 32'hA5C3_5A3C);
    send_item(CmdEncode, 8'h01, 6'h3F, 32'hFFFF_FFFF);
    // bits above the length are ignored: code is 101
    send_item(CmdLoad, 8'h02, 6'd3, 32'hFFFF_FFF5);
    send_item(CmdEncode, 8'h02, '0, '0);
    // 3 pending plus 32 bits: four bytes, three bits left
    send_item(CmdEncode, 8'hFF, '0, '0);
    // missing entry with bits pending, they must survive
    send_item(CmdEncode, 8'h7E, '0, '0);
    send_item(CmdFlush, 8'h7E, '0, '0);
    // 7 pending plus 32 bits: four bytes, seven bits left to flush
    send_item(CmdLoad, 8'h80, 6'd7, 32'h0000_0055);
    send_item(CmdEncode, 8'h80, '0, '0);
    send_item(CmdEncode, 8'hFF, '0, '0);
    send_item(CmdFlush, 8'h00, '0, '0);
    // saturated all-zero code
    send_item(CmdLoad, 8'h40, 6'd40, 32'h0000_0000);
    send_item(CmdEncode, 8'h40, '0, '0);
    // exactly one byte
    send_item(CmdLoad, 8'h03, 6'd8, 32'h0000_00C3);
    send_item(CmdEncode, 8'h03, '0, '0);
    // single bit then flush pads seven zeros
    send_item(CmdLoad, 8'h04, 6'd1, 32'h0000_0001);
    send_item(CmdEncode, 8'h04, '0, '0);
    send_item(CmdFlush, 8'h04, '0, '0);

    // random part in phases, idling toggled, none in the last one
    idling = 1'b1;
    run_traffic(90);
    idling = 1'b0;
    run_traffic(40);
    idling = 1'b1;
    run_traffic(50);
    idling = 1'b0;
    run_traffic(35);
    send_item(CmdFlush, 8'h00, '0, '0);
    in_ch.valid <= 1'b0;

    // drain the expected bytes, then give the block time for strays
    while (waiting_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d items (loads, encodes, flushes, reserved) over %0d table entries",
             items_sent, loaded_syms.size());
    $display("checked %0d packed bytes and %0d missing-entry results, %0d mismatches",
             bytes_checked, errors_checked, fail_count);
    if (fail_count == 0 && waiting_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
